// ===== hdl/kmv_pkg.sv =====
// Shared widths, constants and types for the KMV distinct-count estimator.
`timescale 1ns / 1ps
`default_nettype none

package kmv_pkg;

   // field widths
   localparam int KMV_N_W      = 31;
   localparam int KMV_TOT_W    = 63;
   localparam int KMV_HASH_W   = 64;
   localparam int KMV_DIV_W    = 32;
   localparam int KMV_QUO_W    = 64;
   localparam int KMV_Z_W      = 3;   // leading zero bytes skipped, 0..4
   localparam int KMV_LSH_W    = 5;   // normalize shift of the count, 0..31
   localparam int KMV_RENORM_W = 7;   // signed rescale amount, -31..32

   // bus widths
   localparam int KMV_REQ_TDATA_W = 160;
   localparam int KMV_RSP_TDATA_W = 64;

   // field positions in req_tdata
   localparam int KMV_REQ_N_LSB    = 0;
   localparam int KMV_REQ_TOT_LSB  = KMV_REQ_N_LSB + KMV_N_W;
   localparam int KMV_REQ_HASH_LSB = KMV_REQ_TOT_LSB + KMV_TOT_W;

   // register reset and parameter defaults
   localparam logic [KMV_N_W-1:0] KMV_MAX_SAMPLES_RST = 31'd1024;
   localparam int KMV_HASH_BYTES_DFLT = 8;

   // queue between front and back
   localparam int KMV_Q_DEPTH = 4;
   localparam int KMV_Q_PTR_W = 2;
   localparam int KMV_Q_CNT_W = 3;

   // one quotient bit per divider stage
   localparam int KMV_DIV_STEPS = 64;

   // classified word handed from front to back
   typedef struct packed {
      logic                           bypass;  // table not full: result is n
      logic [KMV_N_W-1:0]             n;
      logic [KMV_TOT_W-1:0]           tot;
      logic [KMV_DIV_W-1:0]           d;
      logic [KMV_LSH_W-1:0]           lsh;
      logic signed [KMV_RENORM_W-1:0] renorm;
   } kmv_item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic [KMV_Q_CNT_W-1:0] count;
      logic                   full;
      logic                   empty;
   } kmv_q_status_type;

endpackage

`default_nettype wire

// ===== hdl/kmv_distinct_count_estimate.sv =====
// Top level of the KMV distinct-count estimator: front, queue, back and the table-size register.
//
//   channel | dir | handshake               | payload
//   req     | in  | req_tvalid/req_tready   | sample_count, total_count, largest_kept_hash
//   rsp     | out | rsp_tvalid/rsp_tready   | estimate
//   csr     | in  | csr_valid/csr_ready     | max_samples (zero is stored as one)
//
// One word per cycle sustained while the output is not stalled by rsp_tready.
// A request passes the front register, the queue, the entry stage, 64 divider stages
// with one quotient bit each, the rescale stage and the output register.
// Synchronous reset clears all valid bits and queue pointers and sets max_samples to 1024.
// rsp_tready low with a result waiting freezes the back end; the 4-entry queue and the
// front register keep taking request words until they are full.
`timescale 1ns / 1ps
`default_nettype none

module kmv_distinct_count_estimate #(
   parameter int HASH_BYTES = kmv_pkg::KMV_HASH_BYTES_DFLT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // sample_count [30:0], total_count [93:31], largest_kept_hash [157:94], zero [159:158]
   input  wire logic [kmv_pkg::KMV_REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // estimate [62:0], zero [63]
   output logic [kmv_pkg::KMV_RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [kmv_pkg::KMV_N_W-1:0]          csr_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready
);

   logic [kmv_pkg::KMV_N_W-1:0]  max_samples_ff;
   logic [kmv_pkg::KMV_N_W-1:0]  max_samples_in;
   kmv_pkg::kmv_q_status_type    q_stat;
   kmv_pkg::kmv_item_type        push_item;
   kmv_pkg::kmv_item_type        pop_item;
   logic                         q_push;
   logic                         q_pop;

   // table size register, a zero write keeps the table at one entry
   assign csr_ready      = 1'b1;
   assign max_samples_in = (csr_data == '0) ? kmv_pkg::KMV_N_W'(1) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_samples_ff <= kmv_pkg::KMV_MAX_SAMPLES_RST;
      end else if (csr_valid && csr_ready) begin
         max_samples_ff <= max_samples_in;
      end
   end

   kmv_front #(
      .HASH_BYTES (HASH_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .max_samples (max_samples_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   kmv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_item (push_item),
      .pop     (q_pop),
      .rd_item (pop_item),
      .stat    (q_stat)
   );

   kmv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (pop_item),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // table size never reads as zero
   a_table_nonzero: assert property (@(posedge clock) disable iff (reset)
      max_samples_ff != '0)
      else $error("table size register holds zero");

   // queue fills by one on a lone push
   a_q_fill: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
      else $error("queue count did not rise on push");

   // queue drains by one on a lone pop
   a_q_drain: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_push) |=> (q_stat.count == $past(q_stat.count) - 1'b1))
      else $error("queue count did not fall on pop");

endmodule

`default_nettype wire

// ===== hdl/kmv_front.sv =====
// Front end: accepts request words, finds divisor and shifts, registers the classified word.
`timescale 1ns / 1ps
`default_nettype none

module kmv_front #(
   parameter int HASH_BYTES = kmv_pkg::KMV_HASH_BYTES_DFLT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [kmv_pkg::KMV_N_W-1:0]          max_samples,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [kmv_pkg::KMV_REQ_TDATA_W-1:0]  req_tdata,
   input  wire kmv_pkg::kmv_q_status_type            q_stat,
   output logic                                      q_push,
   output kmv_pkg::kmv_item_type                     q_item
);

   localparam int MAX_Z = HASH_BYTES - 4;

   logic [kmv_pkg::KMV_N_W-1:0]             n;
   logic [kmv_pkg::KMV_TOT_W-1:0]           tot;
   logic [kmv_pkg::KMV_HASH_W-1:0]          h;
   logic [kmv_pkg::KMV_Z_W-1:0]             zc;
   logic                                    z_done;
   logic [kmv_pkg::KMV_DIV_W-1:0]           d_sel;
   logic [kmv_pkg::KMV_LSH_W-1:0]           lsh;
   kmv_pkg::kmv_item_type                   item_in;
   kmv_pkg::kmv_item_type                   item_ff;
   logic                                    valid_ff;
   logic                                    valid_in;
   logic                                    take;

   // unpack fields
   assign n   = req_tdata[kmv_pkg::KMV_REQ_N_LSB +: kmv_pkg::KMV_N_W];
   assign tot = req_tdata[kmv_pkg::KMV_REQ_TOT_LSB +: kmv_pkg::KMV_TOT_W];
   assign h   = req_tdata[kmv_pkg::KMV_REQ_HASH_LSB +: kmv_pkg::KMV_HASH_W];

   // count leading zero bytes of the hash, at most MAX_Z
   always_comb begin
      zc     = '0;
      z_done = 1'b0;
      for (int i = 0; i < MAX_Z; i++) begin
         if (!z_done && (h[(HASH_BYTES-1-i)*8 +: 8] == 8'd0)) begin
            zc = zc + 1'b1;
         end else begin
            z_done = 1'b1;
         end
      end
   end

   // 32-bit divisor window right after the skipped bytes
   always_comb begin
      d_sel = h[MAX_Z*8 +: kmv_pkg::KMV_DIV_W];
      for (int i = 1; i <= MAX_Z; i++) begin
         if (zc == kmv_pkg::KMV_Z_W'(i)) begin
            d_sel = h[(MAX_Z-i)*8 +: kmv_pkg::KMV_DIV_W];
         end
      end
   end

   // shift that brings the top set bit of n to bit 31 of a 32-bit word
   always_comb begin
      lsh = '0;
      for (int i = 0; i < kmv_pkg::KMV_N_W; i++) begin
         if (n[i]) begin
            lsh = kmv_pkg::KMV_LSH_W'(kmv_pkg::KMV_N_W - i);
         end
      end
   end

   // classified word
   always_comb begin
      item_in.bypass = (n < max_samples);
      item_in.n      = n;
      item_in.tot    = tot;
      item_in.d      = (d_sel == '0) ? kmv_pkg::KMV_DIV_W'(1) : d_sel;
      item_in.lsh    = lsh;
      item_in.renorm = $signed({1'b0, zc, 3'b000}) - $signed({2'b00, lsh});
   end

   // one register stage, drained into the queue when it has room
   assign q_push     = valid_ff && !q_stat.full;
   assign req_tready = !valid_ff || !q_stat.full;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !q_push);
   assign q_item     = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/kmv_queue.sv =====
// Short FIFO of classified words between front and back.
`timescale 1ns / 1ps
`default_nettype none

module kmv_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire kmv_pkg::kmv_item_type       wr_item,
   input  wire logic                        pop,
   output kmv_pkg::kmv_item_type            rd_item,
   output kmv_pkg::kmv_q_status_type        stat
);

   kmv_pkg::kmv_item_type                 mem_ff [kmv_pkg::KMV_Q_DEPTH];
   logic [kmv_pkg::KMV_Q_PTR_W-1:0]       wr_ptr_ff;
   logic [kmv_pkg::KMV_Q_PTR_W-1:0]       rd_ptr_ff;
   logic [kmv_pkg::KMV_Q_CNT_W-1:0]       count_ff;
   logic [kmv_pkg::KMV_Q_CNT_W-1:0]       count_in;

   assign rd_item    = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == kmv_pkg::KMV_Q_CNT_W'(kmv_pkg::KMV_Q_DEPTH));
   assign stat.empty = (count_ff == '0);

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/kmv_back.sv =====
// Back end: pipelined 64/32 restoring divider, rescale, clamp and output register.
`timescale 1ns / 1ps
`default_nettype none

module kmv_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire kmv_pkg::kmv_item_type                q_item,
   input  wire kmv_pkg::kmv_q_status_type            q_stat,
   output logic                                      q_pop,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [kmv_pkg::KMV_RSP_TDATA_W-1:0]       rsp_tdata
);

   localparam int STEPS = kmv_pkg::KMV_DIV_STEPS;

   // one divider stage; for a bypass word tot carries n
   typedef struct packed {
      logic                                    valid;
      logic                                    bypass;
      logic [kmv_pkg::KMV_DIV_W-1:0]           rem;
      logic [kmv_pkg::KMV_QUO_W-1:0]           dq;   // dividend bits out, quotient bits in
      logic [kmv_pkg::KMV_DIV_W-1:0]           d;
      logic [kmv_pkg::KMV_TOT_W-1:0]           tot;
      logic signed [kmv_pkg::KMV_RENORM_W-1:0] renorm;
   } stage_type;

   typedef struct packed {
      logic                            valid;
      logic                            bypass;
      logic                            ovf;
      logic [kmv_pkg::KMV_QUO_W-1:0]   rr;
      logic [kmv_pkg::KMV_TOT_W-1:0]   tot;
   } scale_type;

   stage_type                          stg_ff [STEPS+1];
   stage_type                          stg_in [STEPS+1];
   scale_type                          scl_ff;
   scale_type                          scl_in;
   logic                               out_valid_ff;
   logic [kmv_pkg::KMV_TOT_W-1:0]      out_data_ff;
   logic [kmv_pkg::KMV_TOT_W-1:0]      est_in;
   logic                               adv;
   logic [kmv_pkg::KMV_DIV_W-1:0]      nn;
   logic [kmv_pkg::KMV_RENORM_W-1:0]   neg_amt;
   logic [kmv_pkg::KMV_TOT_W-1:0]      tot_sh;
   stage_type                          last;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic stage_type div_step(input stage_type s);
      stage_type   o;
      logic [32:0] t;
      logic [32:0] diff;
      o    = s;
      t    = {s.rem, s.dq[kmv_pkg::KMV_QUO_W-1]};
      diff = t - {1'b0, s.d};
      if (!diff[32]) begin
         o.rem = diff[31:0];
         o.dq  = {s.dq[kmv_pkg::KMV_QUO_W-2:0], 1'b1};
      end else begin
         o.rem = t[31:0];
         o.dq  = {s.dq[kmv_pkg::KMV_QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // whole back end moves together unless the output word is stuck
   assign adv   = !out_valid_ff || rsp_tready;
   assign q_pop = adv && !q_stat.empty;

   // entry: normalize the count into the top of the dividend
   assign nn = {1'b0, q_item.n} << q_item.lsh;

   always_comb begin
      stg_in[0].valid  = q_pop;
      stg_in[0].bypass = q_item.bypass;
      stg_in[0].rem    = '0;
      stg_in[0].dq     = {nn, {kmv_pkg::KMV_DIV_W{1'b0}}};
      stg_in[0].d      = q_item.d;
      stg_in[0].tot    = q_item.bypass ? {32'd0, q_item.n} : q_item.tot;
      stg_in[0].renorm = q_item.renorm;
      for (int k = 1; k <= STEPS; k++) begin
         stg_in[k] = div_step(stg_ff[k-1]);
      end
   end

   // rescale by byte and bit shifts; overflow check on the upscale side
   assign last    = stg_ff[STEPS];
   assign neg_amt = -last.renorm;
   assign tot_sh  = last.tot >> last.renorm[kmv_pkg::KMV_LSH_W-1:0];

   always_comb begin
      scl_in.valid  = last.valid;
      scl_in.bypass = last.bypass;
      scl_in.tot    = last.tot;
      if (last.renorm[kmv_pkg::KMV_RENORM_W-1]) begin
         scl_in.ovf = 1'b0;
         scl_in.rr  = last.dq >> neg_amt[kmv_pkg::KMV_LSH_W-1:0];
      end else begin
         scl_in.ovf = (last.dq > {1'b0, tot_sh});
         scl_in.rr  = last.dq << last.renorm[kmv_pkg::KMV_LSH_W-1:0];
      end
   end

   // clamp to the total
   always_comb begin
      if (scl_ff.bypass || scl_ff.ovf || (scl_ff.rr > {1'b0, scl_ff.tot})) begin
         est_in = scl_ff.tot;
      end else begin
         est_in = scl_ff.rr[kmv_pkg::KMV_TOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) begin
            stg_ff[k].valid <= 1'b0;
         end
         scl_ff.valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k <= STEPS; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         scl_ff       <= scl_in;
         out_valid_ff <= scl_ff.valid;
         out_data_ff  <= est_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule

`default_nettype wire

// ===== verif/kmv_distinct_count_estimate_tb.sv =====
// Self-checking testbench for kmv_distinct_count_estimate against an estimate predictor.
`timescale 1ns / 1ps

module kmv_distinct_count_estimate_tb;

   localparam int HASH_BYTES   = kmv_pkg::KMV_HASH_BYTES_DFLT;
   localparam int RESET_CYCLES = 9;
   localparam int STALL_LIMIT  = 4000;   // cycles without any accepted word
   localparam int TAIL_CYCLES  = 150;    // outlasts the pipeline
   localparam int MAX_REPORTS  = 10;
   localparam int CHUNK_ITEMS  = 137;
   localparam logic [kmv_pkg::KMV_N_W-1:0]   N_MAX   = '1;
   localparam logic [kmv_pkg::KMV_TOT_W-1:0] TOT_MAX = '1;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic [kmv_pkg::KMV_REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [kmv_pkg::KMV_RSP_TDATA_W-1:0]  rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [kmv_pkg::KMV_N_W-1:0]          csr_data   = '0;
   logic                                 csr_valid  = 1'b0;
   logic                                 csr_ready;

   // local copy of the table-size register
   logic [kmv_pkg::KMV_N_W-1:0]   table_size = kmv_pkg::KMV_MAX_SAMPLES_RST;
   logic [kmv_pkg::KMV_TOT_W-1:0] expected_estimates[$];
   int                            req_idle_pct  = 0;
   int                            rsp_stall_pct = 0;
   int                            failure_count = 0;
   int                            quiet_cycles  = 0;

   kmv_distinct_count_estimate #(
      .HASH_BYTES(HASH_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_data  (csr_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready)
   );

   always #4 clock = ~clock;

   // estimate of one sketch: bypass while the table is not full, else scaled division
   function automatic logic [kmv_pkg::KMV_TOT_W-1:0] predict_estimate(
         input logic [kmv_pkg::KMV_N_W-1:0]    count,
         input logic [kmv_pkg::KMV_TOT_W-1:0]  total,
         input logic [kmv_pkg::KMV_HASH_W-1:0] hash,
         input logic [kmv_pkg::KMV_N_W-1:0]    tsize);
      int unsigned skip;
      int unsigned top;
      int          shift;
      logic [31:0] divisor;
      logic [31:0] norm;
      logic [63:0] quot;
      if (count < tsize) return {32'd0, count};
      // skip leading zero bytes, keep at least four
      skip = 0;
      while (skip + 4 < HASH_BYTES && hash[(HASH_BYTES-1-skip)*8 +: 8] == 8'd0) skip++;
      divisor = hash[(HASH_BYTES-4-skip)*8 +: 32];
      if (divisor == 32'd0) divisor = 32'd1;
      top = 30;
      while (top > 0 && !count[top]) top--;
      norm  = 32'(count) << (31 - top);
      quot  = {norm, 32'd0} / {32'd0, divisor};
      shift = int'(skip * 8) - int'(31 - top);
      if (shift < 0) begin
         quot = quot >> (-shift);
      end else begin
         if (quot > ({1'b0, total} >> shift)) return total;
         quot = quot << shift;
      end
      if (quot > {1'b0, total}) quot = {1'b0, total};
      return quot[kmv_pkg::KMV_TOT_W-1:0];
   endfunction

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
   endtask

   // result side: random back-pressure and compare against the oldest expectation
   always @(posedge clock) begin
      logic [kmv_pkg::KMV_TOT_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_estimates.size() == 0) begin
            note_failure($sformatf("unexpected estimate word 0x%016h", rsp_tdata));
         end else begin
            want = expected_estimates.pop_front();
            if (rsp_tdata !== {1'b0, want})
               note_failure($sformatf("estimate expected 0x%016h got 0x%016h",
                                      {1'b0, want}, rsp_tdata));
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request word, with an optional random gap before it
   task automatic send_sketch(input logic [kmv_pkg::KMV_N_W-1:0]    count,
                              input logic [kmv_pkg::KMV_TOT_W-1:0]  total,
                              input logic [kmv_pkg::KMV_HASH_W-1:0] hash);
      int                                  gap;
      logic [kmv_pkg::KMV_REQ_TDATA_W-1:0] req_word;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word = '0;
      req_word[kmv_pkg::KMV_REQ_N_LSB +: kmv_pkg::KMV_N_W]       = count;
      req_word[kmv_pkg::KMV_REQ_TOT_LSB +: kmv_pkg::KMV_TOT_W]   = total;
      req_word[kmv_pkg::KMV_REQ_HASH_LSB +: kmv_pkg::KMV_HASH_W] = hash;
      req_tdata  <= req_word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_estimates = {expected_estimates,
                            predict_estimate(count, total, hash, table_size)};
   endtask

   // let every outstanding estimate come back; ends on a rising edge
   task automatic drain_estimates();
      req_tvalid <= 1'b0;
      while (expected_estimates.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_table_size(input logic [kmv_pkg::KMV_N_W-1:0] value);
      drain_estimates();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      table_size = (value == '0) ? kmv_pkg::KMV_N_W'(1) : value;
   endtask

   // reset value of the table size: bypass below it, estimation at and above
   task automatic test_table_not_full();
      send_sketch('0, '0, '0);
      send_sketch(31'd1023, 63'd5, '1);
      send_sketch(31'd1024, TOT_MAX, '1);
      send_sketch(N_MAX, TOT_MAX, '0);
   endtask

   // zero written as table size, leading zero bytes, overflow, clamp
   task automatic test_zero_table_size();
      write_table_size('0);
      send_sketch('0, TOT_MAX, 64'hDEAD_BEEF_0000_0000);
      send_sketch(31'd1, TOT_MAX, 64'd1);
      send_sketch(31'd1, TOT_MAX, '1);
      for (int lz = 0; lz < 8; lz++)
         send_sketch(N_MAX, lz[0] ? TOT_MAX : 63'd1000, 64'h8000_0000_0000_0001 >> (8 * lz));
      send_sketch(N_MAX, '0, '1);
   endtask

   // largest table size: only a full count estimates
   task automatic test_full_table_size();
      write_table_size(N_MAX);
      send_sketch(N_MAX - 31'd1, '0, '1);
      send_sketch(N_MAX, kmv_pkg::KMV_TOT_W'({$urandom, $urandom}), {$urandom, $urandom});
   endtask

   task automatic make_random_sketch(output logic [kmv_pkg::KMV_N_W-1:0]    count,
                                     output logic [kmv_pkg::KMV_TOT_W-1:0]  total,
                                     output logic [kmv_pkg::KMV_HASH_W-1:0] hash);
      int                            bit_len;
      logic [kmv_pkg::KMV_TOT_W-1:0] est;
      logic [63:0]                   near;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            bit_len = $urandom_range(31, 1);
            count   = kmv_pkg::KMV_N_W'(($urandom | 32'h8000_0000) >> (32 - bit_len));
         end
         4, 5, 6: count = kmv_pkg::KMV_N_W'($urandom_range(32'h7FFF_FFFF, 32'(table_size)));
         7:       count = table_size;
         8:       count = table_size - 1'b1;
         default: count = kmv_pkg::KMV_N_W'($urandom);
      endcase
      hash = {$urandom, $urandom};
      hash = hash >> (8 * $urandom_range(7));
      if ($urandom_range(7) == 0)
         for (int b = 0; b < 8; b++)
            if ($urandom_range(1)) hash[b*8 +: 8] = 8'd0;
      if ($urandom_range(49) == 0) hash = '0;
      case ($urandom_range(9))
         0, 1, 2: total = kmv_pkg::KMV_TOT_W'({$urandom, $urandom});
         3, 4, 5: begin
            // straddle the clamp boundary
            est  = predict_estimate(count, TOT_MAX, hash, table_size);
            near = {1'b0, est} + 64'($urandom_range(4));
            near = (near >= 64'd2) ? near - 64'd2 : 64'd0;
            if (near > {1'b0, TOT_MAX}) near = {1'b0, TOT_MAX};
            total = near[kmv_pkg::KMV_TOT_W-1:0];
         end
         6, 7:    total = kmv_pkg::KMV_TOT_W'($urandom);
         8:       total = TOT_MAX;
         default: total = '0;
      endcase
   endtask

   // random stream over several table sizes with the given idle rates
   task automatic test_random_stream(input int send_idle, input int recv_stall);
      logic [kmv_pkg::KMV_N_W-1:0]    count;
      logic [kmv_pkg::KMV_TOT_W-1:0]  total;
      logic [kmv_pkg::KMV_HASH_W-1:0] hash;
      req_idle_pct  = send_idle;
      rsp_stall_pct = recv_stall;
      for (int chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0:       write_table_size(kmv_pkg::KMV_N_W'($urandom_range(4096, 1)));
            1:       write_table_size(kmv_pkg::KMV_N_W'($urandom_range(1)));
            2:       write_table_size(kmv_pkg::KMV_N_W'($urandom_range(32'h7FFF_FFFF, 1)));
            default: write_table_size(N_MAX);
         endcase
         for (int i = 0; i < CHUNK_ITEMS; i++) begin
            make_random_sketch(count, total, hash);
            send_sketch(count, total, hash);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct  = 11;
      rsp_stall_pct = 67;
      test_table_not_full();
      test_zero_table_size();
      test_full_table_size();
      test_random_stream(11, 67);
      test_random_stream(67, 11);
      test_random_stream(0, 0);
      // wait out the pipeline so stray words are caught
      drain_estimates();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_estimates.size() != 0)
         note_failure($sformatf("%0d estimates never arrived", expected_estimates.size()));
      if (failure_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== kmv_distinct_count_estimate.f =====
hdl/kmv_pkg.sv
hdl/kmv_front.sv
hdl/kmv_queue.sv
hdl/kmv_back.sv
hdl/kmv_distinct_count_estimate.sv
verif/kmv_distinct_count_estimate_tb.sv
